/* rtl/iptp_pkg.sv */
`timescale 1ns / 1ps
package iptp_pkg;

    localparam int unsigned MAX_TEXT_LENGTH = 45;

    localparam logic [5:0] TEXT_LENGTH_SAT = 6'd63;

    localparam logic [1:0] FAM_V4 = 2'd0;
    localparam logic [1:0] FAM_V6 = 2'd1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SYNTAX = 2'd1;
    localparam logic [1:0] ST_FAMILY = 2'd2;

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_LEAD  = 3'd1;
    localparam logic [2:0] PH_BODY  = 3'd2;
    localparam logic [2:0] PH_GCOL  = 3'd3;
    localparam logic [2:0] PH_TAIL  = 3'd4;
    localparam logic [2:0] PH_ZONE  = 3'd5;

    localparam logic [7:0] CH_END     = 8'h00;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    localparam logic [12:0] OCTET_MAX = 13'd255;

    typedef struct packed {
        logic [15:0][7:0] bytes;
        logic [4:0]       wp;
        logic [4:0]       cp;
        logic             cseen;
        logic [15:0]      hgv;
        logic [2:0]       hdc;
        logic [8:0]       tdv;
        logic             tdvalid;
        logic [2:0]       oc;
        logic             ods;
        logic [2:0]       phase;
        logic [5:0]       tlen;
        logic             err;
    } t_state;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] high;
        logic [63:0] low;
    } t_result;

    localparam t_state STATE_RESET = '{
        bytes:   '0,
        wp:      5'd0,
        cp:      5'd0,
        cseen:   1'b0,
        hgv:     16'd0,
        hdc:     3'd0,
        tdv:     9'd0,
        tdvalid: 1'b1,
        oc:      3'd0,
        ods:     1'b0,
        phase:   PH_START,
        tlen:    6'd0,
        err:     1'b0
    };

    // Bit 4 flags a hex digit; bits 3:0 hold its value.
    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, 4'(c - CH_ZERO)};
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
        end
        return r;
    endfunction

    function automatic t_state f_v4(input t_state si, input logic [7:0] c,
                                    input logic [4:0] base);
        t_state      s;
        logic [12:0] nw;
        logic [3:0]  idx;
        s = si;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            nw = 13'(s.tdv) * 13'd10 + 13'(c - CH_ZERO);
            if (s.ods && s.tdv == 9'd0) begin
                s.err = 1'b1;
                return s;
            end
            if (nw > OCTET_MAX) begin
                s.err = 1'b1;
                return s;
            end
            s.tdv = nw[8:0];
            if (!s.ods) begin
                s.oc = s.oc + 3'd1;
                if (s.oc > 3'd4) begin
                    s.err = 1'b1;
                    return s;
                end
                s.ods = 1'b1;
            end
            idx = 4'(base + 5'(s.oc) - 5'd1);
            s.bytes[idx] = s.tdv[7:0];
        end else if (c == CH_DOT && s.ods) begin
            if (s.oc == 3'd4) begin
                s.err = 1'b1;
                return s;
            end
            s.tdv = 9'd0;
            s.ods = 1'b0;
        end else begin
            s.err = 1'b1;
        end
        return s;
    endfunction

    function automatic t_state f_flush(input t_state si);
        t_state s;
        s = si;
        if (s.wp > 5'd14) begin
            s.err = 1'b1;
            return s;
        end
        s.bytes[s.wp[3:0]] = s.hgv[15:8];
        s.bytes[4'(s.wp + 5'd1)] = s.hgv[7:0];
        s.wp = s.wp + 5'd2;
        s.hgv = 16'd0;
        s.hdc = 3'd0;
        return s;
    endfunction

    // Closes the IPv6 text and expands the compression gap with zeros.
    function automatic t_state f_finish(input t_state si);
        t_state           s;
        logic [15:0][7:0] ex;
        logic [4:0]       gap;
        logic [4:0]       src;
        s = si;
        if (s.err) begin
            return s;
        end
        if (s.phase == PH_LEAD || s.phase == PH_GCOL) begin
            s.err = 1'b1;
            return s;
        end
        if (s.phase == PH_TAIL) begin
            if (s.oc < 3'd4) begin
                s.err = 1'b1;
                return s;
            end
            s.wp = s.wp + 5'd4;
        end
        if (s.hdc > 3'd0) begin
            s = f_flush(s);
            if (s.err) begin
                return s;
            end
        end
        if (s.cseen) begin
            if (s.wp >= 5'd16 || s.cp > s.wp) begin
                s.err = 1'b1;
                return s;
            end
            gap = 5'd16 - s.wp;
            for (int j = 0; j < 16; j++) begin
                src = 5'(j) - gap;
                if (5'(j) < s.cp) begin
                    ex[j] = s.bytes[j];
                end else if (5'(j) < s.cp + gap) begin
                    // Only the bytes that moved up are cleared; the rest keep their value.
                    ex[j] = (5'(j) < s.wp) ? 8'd0 : s.bytes[j];
                end else begin
                    ex[j] = s.bytes[src[3:0]];
                end
            end
            s.bytes = ex;
            s.wp = 5'd16;
        end
        if (s.wp != 5'd16) begin
            s.err = 1'b1;
        end
        return s;
    endfunction

    function automatic t_state f_v6(input t_state si, input logic [7:0] c);
        t_state      s;
        logic [4:0]  h;
        logic [12:0] nw;
        s = si;
        if (s.phase == PH_ZONE) begin
            return s;
        end
        if (c == CH_PERCENT) begin
            if (s.tlen > 6'(MAX_TEXT_LENGTH)) begin
                s.err = 1'b1;
            end
            s = f_finish(s);
            s.phase = PH_ZONE;
            return s;
        end
        if (s.tlen < TEXT_LENGTH_SAT) begin
            s.tlen = s.tlen + 6'd1;
        end
        if (s.phase == PH_START) begin
            if (c == CH_COLON) begin
                s.phase = PH_LEAD;
                return s;
            end
            s.phase = PH_BODY;
        end else if (s.phase == PH_LEAD) begin
            if (c != CH_COLON) begin
                s.err = 1'b1;
                return s;
            end
            s.phase = PH_BODY;
        end
        if (s.phase == PH_TAIL) begin
            return f_v4(s, c, s.wp);
        end
        h = f_hex(c);
        if (h[4]) begin
            s.hgv = {s.hgv[11:0], h[3:0]};
            s.hdc = s.hdc + 3'd1;
            if (s.hdc > 3'd4) begin
                s.err = 1'b1;
                return s;
            end
            if (s.tdvalid) begin
                nw = 13'(s.tdv) * 13'd10 + 13'(h[3:0]);
                if (h[3:0] > 4'd9) begin
                    s.tdvalid = 1'b0;
                end else if (s.ods && s.tdv == 9'd0) begin
                    s.tdvalid = 1'b0;
                end else if (nw > OCTET_MAX) begin
                    s.tdvalid = 1'b0;
                end else begin
                    s.tdv = nw[8:0];
                    s.ods = 1'b1;
                end
            end
            s.phase = PH_BODY;
        end else if (c == CH_COLON) begin
            s.tdv = 9'd0;
            s.tdvalid = 1'b1;
            s.ods = 1'b0;
            if (s.hdc == 3'd0) begin
                if (s.cseen) begin
                    s.err = 1'b1;
                    return s;
                end
                s.cseen = 1'b1;
                s.cp = s.wp;
                s.phase = PH_BODY;
            end else begin
                s = f_flush(s);
                s.phase = PH_GCOL;
            end
        end else if (c == CH_DOT && s.tdvalid && s.ods && s.wp <= 5'd12) begin
            s.bytes[s.wp[3:0]] = s.tdv[7:0];
            s.oc = 3'd1;
            s.ods = 1'b0;
            s.tdv = 9'd0;
            s.hdc = 3'd0;
            s.hgv = 16'd0;
            s.phase = PH_TAIL;
        end else begin
            s.err = 1'b1;
        end
        return s;
    endfunction

endpackage

/* rtl/iptp_step.sv */
`timescale 1ns / 1ps
module iptp_step import iptp_pkg::*; (
    input  t_state     i_state,
    input  logic [1:0] i_family,
    input  logic [7:0] i_character,
    output t_state     o_state,
    output t_result    o_result
);

    t_state w_fin;

    always_comb begin
        w_fin = i_state;
        if (i_state.phase != PH_ZONE) begin
            w_fin = f_finish(i_state);
        end
    end

    always_comb begin
        o_state = i_state;
        o_result = '{status: ST_FAMILY, high: 64'd0, low: 64'd0};
        if (i_character != CH_END) begin
            if (!i_state.err) begin
                if (i_family == FAM_V4) begin
                    o_state = f_v4(i_state, i_character, 5'd0);
                end else if (i_family == FAM_V6) begin
                    o_state = f_v6(i_state, i_character);
                end
            end
        end else begin
            o_state = STATE_RESET;
            if (i_family == FAM_V4) begin
                if (i_state.err || i_state.oc < 3'd4) begin
                    o_result.status = ST_SYNTAX;
                end else begin
                    o_result.status = ST_OK;
                    o_result.low = {32'd0, i_state.bytes[0], i_state.bytes[1],
                                    i_state.bytes[2], i_state.bytes[3]};
                end
            end else if (i_family == FAM_V6) begin
                if (w_fin.err) begin
                    o_result.status = ST_SYNTAX;
                end else begin
                    o_result.status = ST_OK;
                    for (int i = 0; i < 8; i++) begin
                        o_result.high[63 - 8 * i -: 8] = w_fin.bytes[i];
                        o_result.low[63 - 8 * i -: 8] = w_fin.bytes[i + 8];
                    end
                end
            end
        end
    end

endmodule

/* rtl/ip_address_text_parser.sv */
`timescale 1ns / 1ps
// A character is captured in the input register, then parsed into the parse state register;
// a terminating zero character also loads the result register that drives o_valid.
// Throughput: one character per cycle unless stalled; a single registered pass updates the state.
// Input stalls only while a terminator waits behind a result that is itself stalled.
// Synchronous active-low reset empties both stages and returns the parse state to its start.
module ip_address_text_parser import iptp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_family,
    input  logic [7:0]  i_character,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [63:0] o_address_high,
    output logic [63:0] o_address_low
);

    logic       r_in_valid;
    logic [1:0] r_in_family;
    logic [7:0] r_in_char;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_result    r_result;
    logic       r_out_valid;
    logic       w_advance;
    logic       w_is_end;

    assign w_is_end  = (r_in_char == CH_END);
    assign w_advance = r_in_valid && (!w_is_end || !r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_advance;

    iptp_step u_step (
        .i_state     (r_state),
        .i_family    (r_in_family),
        .i_character (r_in_char),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_in_family <= i_family;
            r_in_char   <= i_character;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_is_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_is_end) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_result.status;
    assign o_address_high = r_result.high;
    assign o_address_low  = r_result.low;

endmodule

/* test/tb_ip_address_text_parser.sv */
`timescale 1ns / 1ps
module tb_ip_address_text_parser;
    import iptp_pkg::*;

    localparam logic [1:0] FAM_OTHER    = 2'd2;
    localparam logic [1:0] FAM_RESERVED = 2'd3;
    localparam int DIR_ROWS    = 25;
    localparam int ITEM_TARGET = 1250;
    localparam int QUIET_FROM  = 1100;
    localparam string NOISE_CHARS = "0123456789abcdefABCDEF::..%gxZ -";

    typedef struct packed {
        logic [1:0] fam;
        logic [7:0] ch;
        logic       typed;
        t_result    res;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_family = FAM_V4;
    logic [7:0]  i_character = CH_END;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [63:0] o_address_high;
    logic [63:0] o_address_low;

    // Parser state mirrored by the checker.
    logic [7:0] addr_bytes [16];
    int         wr_pos;
    int         gap_pos;
    bit         gap_seen;
    int         grp_val;
    int         grp_digits;
    int         dec_val;
    bit         dec_ok;
    int         octets;
    bit         octet_open;
    logic [2:0] phase;
    int         text_len;
    bit         bad;

    t_result    expected_parses [$];
    logic [7:0] text_buf [$];
    t_stim_row  dir_table [DIR_ROWS];
    int         n_items;
    int         fail_count;
    int         send_gap_pct;
    int         hold_pct;

    ip_address_text_parser u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_family       (i_family),
        .i_character    (i_character),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_address_high (o_address_high),
        .o_address_low  (o_address_low)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic clear_parser();
        for (int i = 0; i < 16; i++) begin
            addr_bytes[i] = 8'd0;
        end
        wr_pos = 0;
        gap_pos = 0;
        gap_seen = 1'b0;
        grp_val = 0;
        grp_digits = 0;
        dec_val = 0;
        dec_ok = 1'b1;
        octets = 0;
        octet_open = 1'b0;
        phase = PH_START;
        text_len = 0;
        bad = 1'b0;
    endtask

    task automatic append_char(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endtask

    function automatic int hex_val(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c) - int'(CH_ZERO);
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
            return int'(c) - int'(CH_LOWER_A) + 10;
        end
        if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            return int'(c) - int'(CH_UPPER_A) + 10;
        end
        return -1;
    endfunction

    // One character of a dotted quad whose first octet lands at base.
    task automatic take_dotted_char(input logic [7:0] c, input int base);
        int nw;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            nw = dec_val * 10 + (int'(c) - int'(CH_ZERO));
            if (octet_open && dec_val == 0) begin
                bad = 1'b1;
                return;
            end
            if (nw > int'(OCTET_MAX)) begin
                bad = 1'b1;
                return;
            end
            dec_val = nw;
            if (!octet_open) begin
                octets++;
                if (octets > 4) begin
                    bad = 1'b1;
                    return;
                end
                octet_open = 1'b1;
            end
            addr_bytes[(base + octets - 1) & 15] = 8'(dec_val);
        end else if (c == CH_DOT && octet_open) begin
            if (octets == 4) begin
                bad = 1'b1;
                return;
            end
            dec_val = 0;
            octet_open = 1'b0;
        end else begin
            bad = 1'b1;
        end
    endtask

    task automatic store_group();
        if (wr_pos > 14) begin
            bad = 1'b1;
            return;
        end
        addr_bytes[wr_pos & 15] = 8'(grp_val >> 8);
        addr_bytes[(wr_pos + 1) & 15] = 8'(grp_val);
        wr_pos += 2;
        grp_val = 0;
        grp_digits = 0;
    endtask

    task automatic close_v6_text();
        int n;
        if (bad) begin
            return;
        end
        if (phase == PH_LEAD || phase == PH_GCOL) begin
            bad = 1'b1;
            return;
        end
        if (phase == PH_TAIL) begin
            if (octets < 4) begin
                bad = 1'b1;
                return;
            end
            wr_pos += 4;
        end
        if (grp_digits > 0) begin
            store_group();
            if (bad) begin
                return;
            end
        end
        if (gap_seen) begin
            if (wr_pos >= 16 || gap_pos > wr_pos) begin
                bad = 1'b1;
                return;
            end
            n = wr_pos - gap_pos;
            for (int i = 1; i <= n; i++) begin
                addr_bytes[(16 - i) & 15] = addr_bytes[(gap_pos + n - i) & 15];
                addr_bytes[(gap_pos + n - i) & 15] = 8'd0;
            end
            wr_pos = 16;
        end
        if (wr_pos != 16) begin
            bad = 1'b1;
        end
    endtask

    task automatic take_v6_char(input logic [7:0] c);
        int h;
        int nw;
        if (phase == PH_ZONE) begin
            return;
        end
        if (c == CH_PERCENT) begin
            if (text_len > MAX_TEXT_LENGTH) begin
                bad = 1'b1;
            end
            close_v6_text();
            phase = PH_ZONE;
            return;
        end
        if (text_len < 63) begin
            text_len++;
        end
        if (phase == PH_START) begin
            if (c == CH_COLON) begin
                phase = PH_LEAD;
                return;
            end
            phase = PH_BODY;
        end else if (phase == PH_LEAD) begin
            if (c != CH_COLON) begin
                bad = 1'b1;
                return;
            end
            phase = PH_BODY;
        end
        if (phase == PH_TAIL) begin
            take_dotted_char(c, wr_pos);
            return;
        end
        h = hex_val(c);
        if (h >= 0) begin
            grp_val = ((grp_val << 4) | h) & 'hFFFF;
            grp_digits++;
            if (grp_digits > 4) begin
                bad = 1'b1;
                return;
            end
            if (dec_ok) begin
                nw = dec_val * 10 + h;
                if (h > 9) begin
                    dec_ok = 1'b0;
                end else if (octet_open && dec_val == 0) begin
                    dec_ok = 1'b0;
                end else if (nw > int'(OCTET_MAX)) begin
                    dec_ok = 1'b0;
                end else begin
                    dec_val = nw;
                    octet_open = 1'b1;
                end
            end
            phase = PH_BODY;
        end else if (c == CH_COLON) begin
            dec_val = 0;
            dec_ok = 1'b1;
            octet_open = 1'b0;
            if (grp_digits == 0) begin
                if (gap_seen) begin
                    bad = 1'b1;
                    return;
                end
                gap_seen = 1'b1;
                gap_pos = wr_pos;
                phase = PH_BODY;
            end else begin
                store_group();
                phase = PH_GCOL;
            end
        end else if (c == CH_DOT && dec_ok && octet_open && wr_pos <= 12) begin
            addr_bytes[wr_pos & 15] = 8'(dec_val);
            octets = 1;
            octet_open = 1'b0;
            dec_val = 0;
            grp_digits = 0;
            grp_val = 0;
            phase = PH_TAIL;
        end else begin
            bad = 1'b1;
        end
    endtask

    task automatic parse_char(input logic [1:0] fam, input logic [7:0] c,
                              output bit got, output t_result r);
        got = 1'b0;
        r = '0;
        if (c != CH_END) begin
            if (!bad) begin
                if (fam == FAM_V4) begin
                    take_dotted_char(c, 0);
                end else if (fam == FAM_V6) begin
                    take_v6_char(c);
                end
            end
            return;
        end
        got = 1'b1;
        if (fam == FAM_V4) begin
            if (!bad && octets < 4) begin
                bad = 1'b1;
            end
            r.status = bad ? ST_SYNTAX : ST_OK;
            if (!bad) begin
                r.low = {32'd0, addr_bytes[0], addr_bytes[1], addr_bytes[2], addr_bytes[3]};
            end
        end else if (fam == FAM_V6) begin
            if (phase != PH_ZONE) begin
                close_v6_text();
            end
            r.status = bad ? ST_SYNTAX : ST_OK;
            if (!bad) begin
                for (int i = 0; i < 8; i++) begin
                    r.high = {r.high[55:0], addr_bytes[i]};
                    r.low = {r.low[55:0], addr_bytes[i + 8]};
                end
            end
        end else begin
            r.status = ST_FAMILY;
        end
        clear_parser();
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_char(input logic [1:0] fam, input logic [7:0] ch,
                             input bit typed, input t_result typed_res);
        bit      got;
        t_result res;
        if (send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_family <= fam;
        i_character <= ch;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        parse_char(fam, ch, got, res);
        if (got) begin
            expected_parses.insert(expected_parses.size(), typed ? typed_res : res);
        end
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            append_char(s[i]);
        end
    endtask

    task automatic push_group(input int cnt);
        int v;
        int nib;
        bit upper;
        v = $urandom_range(0, (1 << (4 * cnt)) - 1);
        upper = 1'($urandom_range(0, 1));
        for (int d = cnt - 1; d >= 0; d--) begin
            nib = (v >> (4 * d)) & 15;
            if (nib < 10) begin
                append_char(8'(int'(CH_ZERO) + nib));
            end else begin
                append_char(8'(int'(upper ? CH_UPPER_A : CH_LOWER_A) + nib - 10));
            end
        end
    endtask

    task automatic push_quad(input bit wide);
        for (int i = 0; i < 4; i++) begin
            if (i > 0) begin
                append_char(CH_DOT);
            end
            push_text($sformatf("%0d", wide ? $urandom_range(100, 255) : $urandom_range(0, 255)));
        end
    endtask

    task automatic mutate_text();
        int         pos;
        int         kind;
        logic [7:0] ch;
        pos = (text_buf.size() == 0) ? 0 : $urandom_range(0, text_buf.size() - 1);
        kind = $urandom_range(0, 2);
        if ($urandom_range(0, 4) == 0) begin
            ch = 8'($urandom_range(1, 255));
        end else begin
            ch = NOISE_CHARS[$urandom_range(0, NOISE_CHARS.len() - 1)];
        end
        if (text_buf.size() == 0 || kind == 0) begin
            text_buf.insert($urandom_range(0, text_buf.size()), ch);
        end else if (kind == 1) begin
            text_buf.delete(pos);
        end else begin
            text_buf[pos] = ch;
        end
    endtask

    task automatic build_v6(input bit flawed, input bit wide);
        bit tail;
        bit gap;
        int k;
        int left;
        text_buf.delete();
        tail = wide ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) == 0);
        gap = wide ? 1'b0 : ($urandom_range(0, 2) != 0);
        k = tail ? 6 : 8;
        if (gap) begin
            k = $urandom_range(0, k - 1);
        end
        left = gap ? $urandom_range(0, k) : k;
        for (int gi = 0; gi < k; gi++) begin
            if (gap && gi == left) begin
                push_text("::");
            end else if (gi > 0) begin
                append_char(CH_COLON);
            end
            push_group(wide ? 4 : $urandom_range(1, 4));
        end
        if (gap && left == k) begin
            push_text("::");
        end
        if (tail) begin
            if (k > 0 && !(gap && left == k)) begin
                append_char(CH_COLON);
            end
            push_quad(wide);
        end
        if ($urandom_range(0, 3) == 0) begin
            append_char(CH_PERCENT);
            repeat ($urandom_range(0, 8)) append_char(8'($urandom_range(1, 255)));
        end
        if (flawed) begin
            repeat ($urandom_range(1, 2)) mutate_text();
        end
    endtask

    task automatic build_v4(input bit flawed);
        text_buf.delete();
        push_quad($urandom_range(0, 3) == 0);
        if (flawed) begin
            repeat ($urandom_range(1, 2)) mutate_text();
        end
    endtask

    task automatic build_noise();
        int len;
        text_buf.delete();
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 12);
        repeat (len) begin
            if ($urandom_range(0, 6) == 0) begin
                append_char(8'($urandom_range(1, 255)));
            end else begin
                append_char(NOISE_CHARS[$urandom_range(0, NOISE_CHARS.len() - 1)]);
            end
        end
    endtask

    task automatic run_text(input logic [1:0] fam, input logic [1:0] end_fam, input bit mix);
        logic [1:0] f;
        foreach (text_buf[i]) begin
            f = (mix && $urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : fam;
            send_char(f, text_buf[i], 1'b0, '0);
        end
        send_char(end_fam, CH_END, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_parses.size() == 0) begin
                $display("%0t: result with no parse pending, status %0d high %h low %h",
                         $time, o_status, o_address_high, o_address_low);
                fail_count++;
            end else begin
                e = expected_parses.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t: status expected %0d, actual %0d", $time, e.status, o_status);
                    fail_count++;
                end
                if (o_address_high !== e.high) begin
                    $display("%0t: address_high expected %h, actual %h",
                             $time, e.high, o_address_high);
                    fail_count++;
                end
                if (o_address_low !== e.low) begin
                    $display("%0t: address_low expected %h, actual %h",
                             $time, e.low, o_address_low);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (i_rst_n && hold_pct > 0 && $urandom_range(1, 100) <= hold_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [1:0] fam;
        logic [1:0] end_fam;
        int         pick;
        n_items = 0;
        fail_count = 0;
        send_gap_pct = 20;
        hold_pct = 20;
        clear_parser();
        dir_table = '{
            '{FAM_V4,       CH_END,     1'b1, '{ST_SYNTAX, 64'd0, 64'd0}},
            '{FAM_V6,       CH_END,     1'b1, '{ST_SYNTAX, 64'd0, 64'd0}},
            '{FAM_OTHER,    CH_END,     1'b1, '{ST_FAMILY, 64'd0, 64'd0}},
            '{FAM_RESERVED, CH_END,     1'b1, '{ST_FAMILY, 64'd0, 64'd0}},
            '{FAM_V6,       CH_COLON,   1'b0, '0},
            '{FAM_V6,       CH_COLON,   1'b0, '0},
            '{FAM_V6,       CH_END,     1'b1, '{ST_OK, 64'd0, 64'd0}},
            '{FAM_V4,       "1",        1'b0, '0},
            '{FAM_V4,       CH_PERCENT, 1'b0, '0},
            '{FAM_V4,       CH_END,     1'b1, '{ST_SYNTAX, 64'd0, 64'd0}},
            '{FAM_V4,       "2",        1'b0, '0},
            '{FAM_V4,       "5",        1'b0, '0},
            '{FAM_V4,       "5",        1'b0, '0},
            '{FAM_V4,       CH_DOT,     1'b0, '0},
            '{FAM_V4,       "0",        1'b0, '0},
            '{FAM_V4,       CH_DOT,     1'b0, '0},
            '{FAM_V4,       "0",        1'b0, '0},
            '{FAM_V4,       CH_DOT,     1'b0, '0},
            '{FAM_V4,       "1",        1'b0, '0},
            '{FAM_V4,       CH_END,     1'b1, '{ST_OK, 64'd0, 64'h0000_0000_FF00_0001}},
            '{FAM_V6,       CH_COLON,   1'b0, '0},
            '{FAM_V6,       CH_COLON,   1'b0, '0},
            '{FAM_V6,       CH_PERCENT, 1'b0, '0},
            '{FAM_V6,       8'hFF,      1'b0, '0},
            '{FAM_V6,       CH_END,     1'b0, '0}
        };
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_char(dir_table[i].fam, dir_table[i].ch, dir_table[i].typed, dir_table[i].res);
        end
        while (n_items < ITEM_TARGET) begin
            if (n_items >= QUIET_FROM) begin
                send_gap_pct = 0;
                hold_pct = 0;
            end else begin
                send_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
                hold_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                fam = FAM_V6;
                build_v6($urandom_range(0, 3) == 0, 1'b0);
            end else if (pick < 50) begin
                fam = FAM_V6;
                build_v6($urandom_range(0, 5) == 0, 1'b1);
            end else if (pick < 78) begin
                fam = FAM_V4;
                build_v4($urandom_range(0, 3) == 0);
            end else begin
                fam = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1))
                                                 : 2'($urandom_range(2, 3));
                build_noise();
            end
            end_fam = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : fam;
            run_text(fam, end_fam, $urandom_range(0, 9) == 0);
        end
        i_valid <= 1'b0;
        while (expected_parses.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
